// ===== rtl/cosr_pkg.sv =====
// ----------------------------------------------------------------------------
// cosr_pkg: shared definitions for the circle octant rasterizer
// Widths, packing, register indexes and state encodings.
// ----------------------------------------------------------------------------
package cosr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 10;

	localparam int OUT_W   = COORD_BITS + 1;   // point coordinate width
	localparam int STATE_W = RADIUS_BITS + 1;  // offset and height width
	localparam int EXT_W   = (OUT_W > STATE_W) ? OUT_W : STATE_W;
	localparam int SQ_W    = 2 * STATE_W;      // square of a state value
	localparam int RAD_W   = 2 * RADIUS_BITS;  // radicand width
	localparam int REM_W   = RADIUS_BITS + 2;  // root remainder width
	localparam int CNT_W   = $clog2(STATE_W);

	localparam int PT_W    = 3;
	localparam logic [PT_W-1:0] LAST_PT = 3'd7;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_COL = 2'd0,
		CFG_CENTER_ROW = 2'd1,
		CFG_RADIUS     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		RT_IDLE,
		RT_MUL,
		RT_SUB,
		RT_SQRT,
		RT_DONE
	} root_state_t;

endpackage

// ===== rtl/cosr_root.sv =====
// ----------------------------------------------------------------------------
// cosr_root: serial height unit
// round(sqrt(max(r*r - o*o, 0))) with a bit-serial squarer and a
// two-bit-per-cycle digit-by-digit root.
// ----------------------------------------------------------------------------
module cosr_root import cosr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RADIUS_BITS-1:0] radius,
	input  logic [STATE_W-1:0] offset,
	output logic               done,
	output logic [STATE_W-1:0] root
);

	root_state_t            phase_q, phase_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [STATE_W-1:0]     rm_q, om_q;
	logic [SQ_W-1:0]        ra_q, oa_q, racc_q, oacc_q;
	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [RADIUS_BITS-1:0] root_q;

	logic [RAD_W-1:0] diff;
	logic [REM_W-1:0] rem_sh, trial;
	logic             take;

	// the difference never exceeds r*r, so it fits the radicand width
	assign diff   = (racc_q > oacc_q) ? RAD_W'(racc_q - oacc_q) : '0;
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			RT_IDLE: if (start) phase_d = RT_MUL;
			RT_MUL:  if (cnt_q == '0) phase_d = RT_SUB;
			RT_SUB:  phase_d = RT_SQRT;
			RT_SQRT: if (cnt_q == '0) phase_d = RT_DONE;
			RT_DONE: phase_d = RT_IDLE;
			default: phase_d = RT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RT_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			unique case (phase_q)
				RT_IDLE: if (start) cnt_q <= CNT_W'(STATE_W - 1);
				RT_MUL:  cnt_q <= cnt_q - 1'b1;
				RT_SUB:  cnt_q <= CNT_W'(RADIUS_BITS - 1);
				RT_SQRT: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			RT_IDLE: begin
				if (start) begin
					rm_q   <= {1'b0, radius};
					om_q   <= offset;
					ra_q   <= SQ_W'({1'b0, radius});
					oa_q   <= SQ_W'(offset);
					racc_q <= '0;
					oacc_q <= '0;
				end
			end
			RT_MUL: begin
				if (rm_q[0]) racc_q <= racc_q + ra_q;
				if (om_q[0]) oacc_q <= oacc_q + oa_q;
				rm_q <= rm_q >> 1;
				om_q <= om_q >> 1;
				ra_q <= ra_q << 1;
				oa_q <= oa_q << 1;
			end
			RT_SUB: begin
				rad_q  <= diff;
				rem_q  <= '0;
				root_q <= '0;
			end
			RT_SQRT: begin
				rad_q <= rad_q << 2;
				if (take) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[RADIUS_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[RADIUS_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// round to nearest: step up when the remainder exceeds the floor root
	assign done = (phase_q == RT_DONE);
	assign root = (rem_q > REM_W'(root_q)) ? (STATE_W'(root_q) + STATE_W'(1))
	                                       : STATE_W'(root_q);

endmodule

// ===== rtl/circle_octant_sqrt_rasterizer.sv =====
// ----------------------------------------------------------------------------
// circle_octant_sqrt_rasterizer: circle tracer with eight-way symmetry
// Walks the column offset of one octant and emits eight points per step.
// ----------------------------------------------------------------------------
// A restart transfer (s_tdata[0] = 1) clears the column offset and loads the
// previous height with the radius; it gives no result; the block stays idle.
// Each tick transfer (s_tdata[0] = 0) checks offset < previous height. If so,
// the height round(sqrt(max(r*r - o*o, 0))) is worked out serially: a
// bit-serial squarer, a subtract step and a two-bit-per-cycle root, then
// eight point transfers, the last with tlast. Otherwise one finished transfer
// (tuser = 1, zero data, tlast = 1) follows via the finish state and the
// output register. One item is in work at a time; s_tready is high only
// while the block is free. Coordinates wrap to COORD_BITS+1 bits.
// Configuration writes are taken at any time but should only be made while
// the block is idle; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module circle_octant_sqrt_rasterizer import cosr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, rest zero
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // point_col, point_row, zero pad
	output logic                   m_tuser,   // finished
	output logic                   m_tlast,   // last
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [COORD_BITS-1:0]  center_col_q, center_row_q;
	logic [RADIUS_BITS-1:0] radius_q;

	// trace state
	logic [STATE_W-1:0] col_offset_q, prev_height_q, height_q;
	state_t             state_q, state_d;
	logic [PT_W-1:0]    k_q;

	// output register
	logic             out_valid_q, out_fin_q, out_last_q;
	logic [OUT_W-1:0] out_col_q, out_row_q;

	// control
	logic s_xfer, slot_free, root_start, root_done;
	logic load_pt, load_fin, trace_on;
	logic [STATE_W-1:0] root_val;

	// point datapath
	logic [OUT_W-1:0] cc, cr, o_ext, h_ext, a_op, b_op, col_pt, row_pt;

	function automatic logic [OUT_W-1:0] fit_out(input logic [STATE_W-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[OUT_W-1:0];
	endfunction

	cosr_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.radius (radius_q),
		.offset (col_offset_q),
		.done   (root_done),
		.root   (root_val)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign trace_on  = (col_offset_q < prev_height_q);

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		load_pt    = 1'b0;
		load_fin   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer && !s_tdata[0]) begin
					if (trace_on) begin
						root_start = 1'b1;
						state_d    = ST_CALC;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CALC: if (root_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					load_pt = 1'b1;
					if (k_q == LAST_PT) state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					load_fin = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// eight-way symmetry: k[2] swaps the roles of offset and height,
	// k[0] picks the column sign, k[1] the row sign
	assign cc     = {center_col_q[COORD_BITS-1], center_col_q};
	assign cr     = {center_row_q[COORD_BITS-1], center_row_q};
	assign o_ext  = fit_out(col_offset_q);
	assign h_ext  = fit_out(height_q);
	assign a_op   = k_q[2] ? h_ext : o_ext;
	assign b_op   = k_q[2] ? o_ext : h_ext;
	assign col_pt = k_q[0] ? (cc + a_op) : (cc - a_op);
	assign row_pt = k_q[1] ? (cr - b_op) : (cr + b_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_COL: center_col_q <= cfg_data[COORD_BITS-1:0];
				CFG_CENTER_ROW: center_row_q <= cfg_data[COORD_BITS-1:0];
				CFG_RADIUS:     radius_q     <= cfg_data[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// trace state: restart loads, last point of a step advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_offset_q  <= '0;
			prev_height_q <= '0;
			k_q           <= '0;
		end else begin
			if (s_xfer && s_tdata[0]) begin
				col_offset_q  <= '0;
				prev_height_q <= {1'b0, radius_q};
			end
			if (state_q == ST_CALC && root_done) begin
				k_q <= '0;
			end
			if (load_pt) begin
				k_q <= k_q + 1'b1;
				if (k_q == LAST_PT) begin
					prev_height_q <= height_q;
					col_offset_q  <= col_offset_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && root_done) height_q <= root_val;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pt || load_fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pt) begin
			out_col_q  <= col_pt;
			out_row_q  <= row_pt;
			out_fin_q  <= 1'b0;
			out_last_q <= (k_q == LAST_PT);
		end else if (load_fin) begin
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_fin_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_row_q, out_col_q});
	assign m_tuser  = out_fin_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/cosr_checker.sv =====
// ----------------------------------------------------------------------------
// cosr_checker: port-level checks for the circle octant rasterizer
// Watches the stream and configuration ports only.
// ----------------------------------------------------------------------------
module cosr_checker import cosr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_IDX_W-1:0]   cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data
);

	// a finished transfer is always the last of its tick
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("finished transfer without tlast");

	// a finished transfer carries no point
	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0))
		else $error("finished transfer with non-zero data");

	// a tick takes the block busy for at least the following cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tdata[0] |=> !s_tready)
		else $error("input taken again straight after a tick");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind circle_octant_sqrt_rasterizer cosr_checker u_cosr_checker (.*);

// ===== tb/circle_octant_sqrt_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// circle_octant_sqrt_rasterizer_tb: self-checking bench for the circle tracer
// Sends restart and tick items on the input stream and checks each point or
// finished transfer against a cycle-free model of the octant walk. Stimulus
// is a short directed set followed by random traces with random centres and
// radii. Both streams idle in random bursts, with a final stretch at full
// rate.
// ----------------------------------------------------------------------------
module circle_octant_sqrt_rasterizer_tb import cosr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam bit RESTART = 1'b1;
	localparam bit TICK    = 1'b0;

	// index 3 decodes to nothing in the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 340;
	localparam int CALM_ITEMS   = 60;   // last random items, sent with no idling
	localparam int SETTLE_CYCLES = 64;  // settle time after the last expected point
	localparam int QUIET_LIMIT  = 5000; // cycles with no transfer at all

	typedef struct packed {
		logic signed [OUT_W-1:0] col;
		logic signed [OUT_W-1:0] row;
		logic                    finished;
		logic                    last;
	} point_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// model of the tracer: configuration and walk state
	logic signed [COORD_BITS-1:0] model_center_col = '0;
	logic signed [COORD_BITS-1:0] model_center_row = '0;
	logic [RADIUS_BITS-1:0]       model_radius     = '0;
	logic [STATE_W-1:0]           model_offset     = '0;
	logic [STATE_W-1:0]           model_height     = '0;

	point_t pending_points[$];

	int  errors     = 0;
	int  items_sent = 0;
	int  quiet      = 0;
	bit  idle_on    = 1'b1;
	int  stall_left = 0;

	always #2 clk = ~clk;

	circle_octant_sqrt_rasterizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [0] restart, rest zero
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [12:0] point_col, [25:13] point_row, zero pad
		.m_tuser  (m_tuser),    // finished
		.m_tlast  (m_tlast),    // last
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// integer root rounded to nearest; a tie cannot arise for whole v
	function automatic int unsigned nearest_root(input int unsigned v);
		int unsigned h;
		int unsigned t;
		h = 0;
		for (int b = STATE_W - 1; b >= 0; b--) begin
			t = h | (32'd1 << b);
			if (t * t <= v)
				h = t;
		end
		if (v - h * h > h)
			h++;
		return h;
	endfunction

	function automatic void queue_point(input int col, input int row, input bit lst);
		point_t p;
		p.col      = OUT_W'(col);
		p.row      = OUT_W'(row);
		p.finished = 1'b0;
		p.last     = lst;
		pending_points.push_back(p);
	endfunction

	// one accepted item: updates the walk and queues the points it yields
	function automatic void trace_step(input bit restart);
		int unsigned r2, o2, radicand, h;
		int cc, cr, o;
		point_t done_pt;
		if (restart) begin
			model_offset = '0;
			model_height = STATE_W'(model_radius);
			return;
		end
		if (!(model_offset < model_height)) begin
			done_pt = '{col: '0, row: '0, finished: 1'b1, last: 1'b1};
			pending_points.push_back(done_pt);
			return;
		end
		r2 = model_radius * model_radius;
		o2 = model_offset * model_offset;
		// offset beyond a shrunk radius: radicand clamps at zero
		radicand = (r2 > o2) ? r2 - o2 : 0;
		h  = nearest_root(radicand);
		cc = model_center_col;
		cr = model_center_row;
		o  = model_offset;
		// coordinates wrap to OUT_W bits inside queue_point
		queue_point(cc - o, cr + h, 1'b0);
		queue_point(cc + o, cr + h, 1'b0);
		queue_point(cc - o, cr - h, 1'b0);
		queue_point(cc + o, cr - h, 1'b0);
		queue_point(cc - h, cr + o, 1'b0);
		queue_point(cc + h, cr + o, 1'b0);
		queue_point(cc - h, cr - o, 1'b0);
		queue_point(cc + h, cr - o, 1'b1);
		model_height = STATE_W'(h);
		model_offset = model_offset + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// one input transfer; tvalid stays high afterwards so a following
	// item can go out back to back, wait_idle lowers it
	task automatic send_item(input bit restart);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
		do @(posedge clk); while (!s_tready);
		trace_step(restart);
		items_sent++;
	endtask

	// drop tvalid, let every expected point arrive, then let any
	// result-free work (restart, finished check) run out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; cfg_valid held high for back-to-back writes
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CENTER_COL: model_center_col = val[COORD_BITS-1:0];
			CFG_CENTER_ROW: model_center_row = val[COORD_BITS-1:0];
			CFG_RADIUS:     model_radius     = val[RADIUS_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
	endtask

	task automatic set_circle(input logic [CFG_DATA_W-1:0] cc,
			input logic [CFG_DATA_W-1:0] cr, input logic [CFG_DATA_W-1:0] r);
		wait_idle();
		write_cfg(CFG_CENTER_COL, cc);
		write_cfg(CFG_CENTER_ROW, cr);
		write_cfg(CFG_RADIUS, r);
		cfg_close();
	endtask

	// sink: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 14);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result check: every output transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		point_t want;
		logic signed [OUT_W-1:0] got_col, got_row;
		if (arst_n && m_tvalid && m_tready) begin
			got_col = m_tdata[OUT_W-1:0];
			got_row = m_tdata[2*OUT_W-1:OUT_W];
			if (pending_points.size() == 0) begin
				$error("unexpected result transfer: col %0d row %0d finished %0b last %0b",
					got_col, got_row, m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (got_col !== want.col) begin
					$error("point_col: expected %0d, got %0d", want.col, got_col);
					errors++;
				end
				if (got_row !== want.row) begin
					$error("point_row: expected %0d, got %0d", want.row, got_row);
					errors++;
				end
				if (m_tuser !== want.finished) begin
					$error("finished: expected %0b, got %0b", want.finished, m_tuser);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog: too long with no transfer on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// straight out of reset the height is zero, so a tick only finishes
	task automatic test_tick_before_restart();
		send_item(TICK);
	endtask

	task automatic test_zero_radius();
		set_circle(12'd0, 12'd0, 12'd0);
		send_item(RESTART);
		send_item(TICK);
	endtask

	// centre at both ends of its range with the largest radius
	task automatic test_extremes();
		set_circle(12'h800, 12'h7FF, 12'd1023);
		send_item(RESTART);
		send_item(TICK);
		send_item(TICK);
		set_circle(12'h7FF, 12'h800, 12'd1023);
		send_item(RESTART);
		send_item(TICK);
	endtask

	// a whole small trace, plus ticks after it has finished
	task automatic test_full_trace();
		set_circle(12'd37, -12'sd19, 12'd5);
		send_item(RESTART);
		repeat (6) send_item(TICK);
	endtask

	// radius cut below the offset mid-trace: height collapses to zero
	task automatic test_radius_shrink();
		set_circle(-12'sd300, 12'd450, 12'd12);
		send_item(RESTART);
		repeat (4) send_item(TICK);
		wait_idle();
		write_cfg(CFG_RADIUS, 12'd2);
		cfg_close();
		send_item(TICK);
		send_item(TICK);
	endtask

	// bits above the radius width dropped, spare index ignored,
	// back-to-back restarts
	task automatic test_cfg_masking();
		wait_idle();
		write_cfg(CFG_RADIUS, 12'hC07);
		write_cfg(CFG_SPARE, 12'hFFF);
		cfg_close();
		send_item(RESTART);
		send_item(RESTART);
		send_item(TICK);
		send_item(TICK);
	endtask

	// random traces: mostly restart then a run of ticks, with some
	// radius changes mid-trace and stray restarts as noise
	task automatic test_random_traces();
		int start;
		int unsigned r, ticks;
		logic [CFG_DATA_W-1:0] r_word;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			idle_on = (items_sent - start < RANDOM_ITEMS - CALM_ITEMS);
			case ($urandom_range(0, 9))
				0:       r = $urandom_range(201, 1023);
				1, 2:    r = $urandom_range(25, 200);
				default: r = $urandom_range(0, 24);
			endcase
			r_word = (CFG_DATA_W'($urandom_range(0, 3)) << RADIUS_BITS) | CFG_DATA_W'(r);
			if ($urandom_range(0, 4) == 0) begin
				wait_idle();
				write_cfg(CFG_RADIUS, r_word);
				cfg_close();
			end else begin
				set_circle(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), r_word);
				send_item(RESTART);
			end
			ticks = $urandom_range(1, (r * 3) / 4 + 3);
			if (ticks > 40)
				ticks = $urandom_range(1, 40);
			repeat (ticks) begin
				if ($urandom_range(0, 19) == 0)
					send_item(RESTART);
				else
					send_item(TICK);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_tick_before_restart();
		test_zero_radius();
		test_extremes();
		test_full_trace();
		test_radius_shrink();
		test_cfg_masking();
		test_random_traces();

		wait_idle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
